FILE: hdl/tmwf_pkg.sv
`timescale 1ns / 1ps

package tmwf_pkg;

  localparam int WINDOW      = 10;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int CH_W      = 2;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TRIMMED   = 2;
  localparam int TRIM_DIV  = WINDOW - TRIMMED;
  localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW + 1);

  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WINDOW-1:0]   window_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic                wr_en;
    logic [CH_IDX_W-1:0] idx;
  } bank_ctl_t;

endpackage

FILE: hdl/trimmed_mean_window_filter.sv
`timescale 1ns / 1ps
// channel | ports                                      | direction
// in      | in_valid, in_ready, in_channel, in_sample  | word in
// out     | out_valid, out_ready, out_channel,         | word out
//         | out_filtered                               |
// One word per cycle unless out_ready stalls; out_valid follows via both registers.
// The window shift, sum, min and max are combinational between the input
// register and the output register; back-to-back words on one channel chain
// through the window lines directly.
// Reset clears all windows to zero and empties both registers.
// A stalled output holds its word; the input register still takes one more word.

module trimmed_mean_window_filter
  import tmwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CH_W-1:0]        out_channel,
  output logic [SAMPLE_BITS-1:0] out_filtered
);

  logic      stg_valid_r;
  chan_t     stg_channel_r;
  sample_t   stg_sample_r;
  logic      out_valid_r;
  chan_t     out_channel_r;
  sample_t   out_filtered_r;

  logic      advance;
  logic      fire;
  logic      ch_ok;
  bank_ctl_t bank_ctl;
  window_t   shifted;
  sample_t   mean;
  sample_t   filtered_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = stg_valid_r && advance;
  assign in_ready = !stg_valid_r || advance;
  assign ch_ok    = (int'(stg_channel_r) < CHANNELS);

  always_comb begin
    bank_ctl.wr_en = fire && ch_ok;
    bank_ctl.idx   = ch_ok ? CH_IDX_W'(stg_channel_r) : '0;
    filtered_nxt   = ch_ok ? mean : '0;
  end

  tmwf_window_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bank_ctl),
    .sample  (stg_sample_r),
    .shifted (shifted)
  );

  tmwf_reduce u_reduce (
    .win      (shifted),
    .filtered (mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= stg_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_channel_r <= in_channel;
      stg_sample_r  <= in_sample;
    end
    if (fire) begin
      out_channel_r  <= stg_channel_r;
      out_filtered_r <= filtered_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_channel  = out_channel_r;
  assign out_filtered = out_filtered_r;

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stg_valid_r)
    else $error("accepted word lost before stage");

  a_fire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && out_channel_r == $past(stg_channel_r))
    else $error("stage word not moved to output");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && int'(out_channel_r) >= CHANNELS |-> out_filtered_r == '0)
    else $error("nonzero result for absent channel");

endmodule

FILE: hdl/tmwf_window_bank.sv
`timescale 1ns / 1ps

module tmwf_window_bank
  import tmwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bank_ctl_t ctl,
  input  sample_t   sample,
  output window_t   shifted
);

  window_t lines_r [CHANNELS];
  window_t sel;

  always_comb begin
    sel = lines_r[ctl.idx];
    for (int i = 0; i < WINDOW - 1; i++) begin
      shifted[i] = sel[i+1];
    end
    shifted[WINDOW-1] = sample;
  end

  // advance the selected channel's line, oldest word drops out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lines_r[c] <= '0;
      end
    end else if (ctl.wr_en) begin
      lines_r[ctl.idx] <= shifted;
    end
  end

endmodule

FILE: hdl/tmwf_reduce.sv
`timescale 1ns / 1ps

module tmwf_reduce
  import tmwf_pkg::*;
(
  input  window_t win,
  output sample_t filtered
);

  sum_t    sum;
  sum_t    diff;
  sum_t    quo;
  sample_t lo;
  sample_t hi;

  always_comb begin
    sum = '0;
    lo  = win[0];
    hi  = win[0];
    for (int i = 0; i < WINDOW; i++) begin
      sum = sum + SUM_W'(win[i]);
      if (win[i] < lo) begin
        lo = win[i];
      end
      if (win[i] > hi) begin
        hi = win[i];
      end
    end
    // drop one minimum and one maximum, average the rest
    diff     = sum - SUM_W'(lo) - SUM_W'(hi);
    quo      = diff / SUM_W'(TRIM_DIV);
    filtered = quo[SAMPLE_BITS-1:0];
  end

endmodule
